// File: design/rtp_pkg.sv
package rtp_pkg;

    // Default table depth. The region field is 8 bits wide, so up to 256 entries.
    localparam int unsigned REGIONS_DEFAULT = 16;
    localparam int unsigned REGION_W        = 8;
    localparam int unsigned STAMP_W         = 64;
    localparam int unsigned COUNT_W         = 32;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_RANGE      = 2'd1,
        ST_BEGIN_OPEN = 2'd2,
        ST_END_CLOSED = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [REGION_W-1:0]   region;
        logic [STAMP_W-1:0]    timestamp;
    } item_t;

    typedef struct packed {
        logic [STAMP_W-1:0]    elapsed_total;
        logic [COUNT_W-1:0]    call_count;
        logic                  is_open;
        status_t               status;
    } result_t;

    // One row of the region table.
    typedef struct packed {
        logic                  open;
        logic [STAMP_W-1:0]    start;
        logic [STAMP_W-1:0]    total;
        logic [COUNT_W-1:0]    count;
    } entry_t;

endpackage

// File: design/region_time_profiler.sv
// A taken beat waits in the input stage while its table row is read; its result
// is then registered in the output stage. Throughput: one beat per cycle unless
// result_ready stalls the output. The row is read as the beat is taken and
// written back as it leaves, with a bypass register for back-to-back hits.
// Reset (rst_n, asynchronous, active low) empties both pipeline registers and
// marks every table row as cleared, so all regions read closed with zero totals.
module region_time_profiler #(
    parameter int unsigned REGIONS = rtp_pkg::REGIONS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  rtp_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_ready,
    output rtp_pkg::result_t result
);

    // Width of a table index. A single-row table still gets one index bit.
    localparam int unsigned IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    // ------------------------------------------------------------------
    // Storage. The table itself is a plain memory with a registered read.
    // Each row has a valid bit in flip-flops; a row whose bit is clear reads
    // as all zero, which is how reset and the clear-all command empty the table.
    // ------------------------------------------------------------------
    rtp_pkg::entry_t  table_mem [REGIONS];
    rtp_pkg::entry_t  rd_data_reg;
    logic [REGIONS-1:0] row_valid_reg;
    logic [REGIONS-1:0] row_valid_next;

    // Input stage: the accepted beat waits here while its row is read.
    logic             in_valid_reg;
    rtp_pkg::item_t   in_reg;

    // Output stage.
    logic             out_valid_reg;
    rtp_pkg::result_t out_reg;
    rtp_pkg::result_t out_next;

    // Bypass: the most recent row written. A beat taken in the same cycle
    // as that write read the memory before the write landed.
    logic             byp_valid_reg;
    logic             byp_valid_next;
    logic [IDX_W-1:0] byp_idx_reg;
    rtp_pkg::entry_t  byp_data_reg;

    // Processing of the beat in the input stage.
    logic             fire;
    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] item_idx;
    rtp_pkg::entry_t  cur;
    rtp_pkg::entry_t  upd;
    logic             wr_en;
    rtp_pkg::status_t status;

    // The stage fires when the output register is empty or being emptied.
    assign fire       = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;
    assign accept     = item_valid && item_ready;

    assign item_idx = item.region[IDX_W-1:0];
    assign idx      = in_reg.region[IDX_W-1:0];
    assign in_range = ({1'b0, in_reg.region} < (rtp_pkg::REGION_W+1)'(REGIONS));

    // Current contents of the addressed row: bypass first, then the valid bit.
    always_comb
    begin
        if (byp_valid_reg && (byp_idx_reg == idx)) begin
            cur = byp_data_reg;
        end else if (row_valid_reg[idx]) begin
            cur = rd_data_reg;
        end else begin
            cur = '0;
        end
    end

    // Command decode and row update.
    always_comb
    begin
        upd    = cur;
        wr_en  = 1'b0;
        status = rtp_pkg::ST_DONE;
        unique case (in_reg.cmd)
            rtp_pkg::CMD_BEGIN:
            begin
                if (cur.open) begin
                    status = rtp_pkg::ST_BEGIN_OPEN;
                end else begin
                    upd.open  = 1'b1;
                    upd.start = in_reg.timestamp;
                    wr_en     = in_range;
                end
            end
            rtp_pkg::CMD_END:
            begin
                if (!cur.open) begin
                    status = rtp_pkg::ST_END_CLOSED;
                end else begin
                    // Both sums wrap: the total mod 2^64, the count mod 2^32.
                    upd.total = cur.total + (in_reg.timestamp - cur.start);
                    upd.count = cur.count + rtp_pkg::COUNT_W'(1);
                    upd.open  = 1'b0;
                    wr_en     = in_range;
                end
            end
            rtp_pkg::CMD_READ:
            begin
                status = rtp_pkg::ST_DONE;
            end
            rtp_pkg::CMD_CLEAR:
            begin
                // The whole table empties; the addressed row reads as zero.
                upd = '0;
            end
            default:
            begin
                status = rtp_pkg::ST_DONE;
            end
        endcase

        if (!in_range) begin
            out_next               = '0;
            out_next.status        = rtp_pkg::ST_RANGE;
        end else begin
            out_next.elapsed_total = upd.total;
            out_next.call_count    = upd.count;
            out_next.is_open       = upd.open;
            out_next.status        = status;
        end
    end

    // Valid bits and bypass state for the next cycle.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        byp_valid_next = byp_valid_reg;
        if (fire) begin
            if (in_reg.cmd == rtp_pkg::CMD_CLEAR) begin
                row_valid_next = '0;
                byp_valid_next = 1'b0;
            end else if (wr_en) begin
                row_valid_next[idx] = 1'b1;
                byp_valid_next      = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            byp_valid_reg <= byp_valid_next;
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_reg <= item;
        end
        if (fire) begin
            out_reg <= out_next;
        end
        if (fire && wr_en) begin
            byp_idx_reg  <= idx;
            byp_data_reg <= upd;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (fire && wr_en) begin
            table_mem[idx] <= upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            rd_data_reg <= table_mem[item_idx];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef ASSERT_OFF
    // A clear-all leaves every row invalid and the bypass empty.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_reg.cmd == rtp_pkg::CMD_CLEAR) |=> (row_valid_reg == '0) && !byp_valid_reg)
        else $error("clear-all did not empty the table");

    // A beat in the input stage that cannot move stays put with its row data.
    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_reg) && $stable(rd_data_reg))
        else $error("stalled input stage changed");

    // An out-of-range region reports nothing but the range status.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == rtp_pkg::ST_RANGE)
            |-> (result.elapsed_total == '0) && (result.call_count == '0) && !result.is_open)
        else $error("out-of-range result carries data");

    // A successful begin leaves the region open; a successful end leaves it closed.
    a_open_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_range && (status == rtp_pkg::ST_DONE)
            && ((in_reg.cmd == rtp_pkg::CMD_BEGIN) || (in_reg.cmd == rtp_pkg::CMD_END))
            |=> (out_reg.is_open == ($past(in_reg.cmd) == rtp_pkg::CMD_BEGIN)))
        else $error("open flag wrong after begin or end");
`endif

endmodule

// File: tb/region_time_profiler_tb.sv
module region_time_profiler_tb;

    localparam int unsigned NUM_REGIONS  = rtp_pkg::REGIONS_DEFAULT;
    localparam int          RANDOM_BEATS = 1900;
    // The limit leaves a wide margin over the slowest correct run, which
    // includes one long receiver hold-off.
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          HOLD_AFTER   = 600;
    // Extra cycles after the last expected result, to catch anything unexpected.
    localparam int          DRAIN_CYCLES = 10;

    // Shadow copy of the region table. Every accepted command beat is applied
    // here, and the region snapshot it should produce is queued in order.
    class profile_table;
        logic                  region_open [NUM_REGIONS];
        logic [63:0]           opened_at   [NUM_REGIONS];
        logic [63:0]           elapsed_sum [NUM_REGIONS];
        logic [31:0]           pair_count  [NUM_REGIONS];
        rtp_pkg::result_t      region_snapshots [$];
        int                    errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_all();
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                region_open[r] = 1'b0;
                opened_at[r]   = '0;
                elapsed_sum[r] = '0;
                pair_count[r]  = '0;
            end
        endfunction

        function void note_command(rtp_pkg::item_t beat);
            rtp_pkg::result_t snap;
            int               r;
            snap = '0;
            snap.status = rtp_pkg::ST_DONE;
            // Clear all wipes the table even when the region number is bad.
            if (beat.cmd == rtp_pkg::CMD_CLEAR)
                clear_all();
            if (beat.region >= NUM_REGIONS)
            begin
                snap.status = rtp_pkg::ST_RANGE;
            end
            else
            begin
                r = int'(beat.region);
                if (beat.cmd == rtp_pkg::CMD_BEGIN)
                begin
                    if (region_open[r])
                        snap.status = rtp_pkg::ST_BEGIN_OPEN;
                    else
                    begin
                        region_open[r] = 1'b1;
                        opened_at[r]   = beat.timestamp;
                    end
                end
                else if (beat.cmd == rtp_pkg::CMD_END)
                begin
                    if (!region_open[r])
                        snap.status = rtp_pkg::ST_END_CLOSED;
                    else
                    begin
                        // Both sums wrap naturally at their widths.
                        elapsed_sum[r] = elapsed_sum[r] + (beat.timestamp - opened_at[r]);
                        pair_count[r]  = pair_count[r] + 32'd1;
                        region_open[r] = 1'b0;
                    end
                end
                snap.elapsed_total = elapsed_sum[r];
                snap.call_count    = pair_count[r];
                snap.is_open       = region_open[r];
            end
            region_snapshots.push_back(snap);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(rtp_pkg::result_t got);
            rtp_pkg::result_t want;
            if (region_snapshots.size() == 0)
            begin
                report_mismatch("result beat arrived with nothing outstanding");
                return;
            end
            want = region_snapshots.pop_front();
            if (got.elapsed_total !== want.elapsed_total)
                report_mismatch($sformatf("elapsed_total got %0h want %0h",
                                          got.elapsed_total, want.elapsed_total));
            if (got.call_count !== want.call_count)
                report_mismatch($sformatf("call_count got %0d want %0d",
                                          got.call_count, want.call_count));
            if (got.is_open !== want.is_open)
                report_mismatch($sformatf("is_open got %b want %b",
                                          got.is_open, want.is_open));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    rtp_pkg::item_t    item;
    logic              result_valid;
    logic              result_ready;
    rtp_pkg::result_t  result;

    profile_table table_model;
    int           cycle_count  = 0;
    int           results_seen = 0;
    logic [63:0]  clock_now;

    region_time_profiler #(
        .REGIONS(NUM_REGIONS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic rtp_pkg::item_t make_beat(rtp_pkg::cmd_t c, int unsigned reg_num,
                                                 logic [63:0] stamp);
        rtp_pkg::item_t b;
        b.cmd       = c;
        b.region    = reg_num[7:0];
        b.timestamp = stamp;
        return b;
    endfunction

    // Offer one command beat after an idle gap and hold it until it is taken.
    // The shadow table is updated at the accepting edge, so later random
    // commands can be shaped from the current region state.
    task send_beat(rtp_pkg::item_t beat, int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (!item_ready);
        table_model.note_command(beat);
        @(negedge clk);
    endtask

    // Random commands are mostly well-formed begin/end pairs on valid regions
    // with a forward-moving clock, so regions accumulate real totals. The rest
    // are reads, rare clears, out-of-range regions, stray commands and wild
    // timestamps that make the elapsed difference wrap.
    function automatic rtp_pkg::item_t random_beat();
        int unsigned   reg_num;
        int unsigned   pick;
        rtp_pkg::cmd_t c;
        logic [63:0]   stamp;
        if ($urandom_range(99) < 90)
            reg_num = $urandom_range(NUM_REGIONS - 1);
        else
            reg_num = $urandom_range(255, NUM_REGIONS);
        pick = $urandom_range(99);
        if (pick < 3)
            c = rtp_pkg::CMD_CLEAR;
        else if (pick < 13)
            c = rtp_pkg::CMD_READ;
        else if (pick < 20)
            c = rtp_pkg::cmd_t'($urandom_range(3));
        else if (reg_num < NUM_REGIONS && table_model.region_open[reg_num])
            c = rtp_pkg::CMD_END;
        else
            c = rtp_pkg::CMD_BEGIN;
        pick = $urandom_range(99);
        if (pick < 4)
            clock_now = {$urandom, $urandom};
        else if (pick < 6)
            clock_now = clock_now - {32'd0, $urandom};
        else
            clock_now = clock_now + 64'($urandom_range(1000, 1));
        stamp = clock_now;
        return make_beat(c, reg_num, stamp);
    endfunction

    // Receiver: draws a stall before every result beat, with stretches of
    // full-rate acceptance, and once holds off for a long while so the
    // pipeline fills and the block pushes back on its input.
    initial
    begin : receiver
        int  stall;
        bit  full_rate;
        bit  held;
        full_rate    = 1'b0;
        held         = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            if (results_seen % 120 == 0)
                full_rate = ($urandom_range(3) == 0);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
                stall = full_rate ? 0 : $urandom_range(6);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            table_model.check_result(result);
            results_seen++;
            @(negedge clk);
        end
    end

    // Sender: reset, a directed pass over the special cases, then the random
    // stream, then a drain before the verdict.
    initial
    begin : sender
        int  gap;
        bit  full_rate;
        table_model  = new();
        clock_now    = 64'd1000;
        full_rate    = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed beats: fresh read, begin twice, end twice, a wrapping
        // interval, out-of-range regions, clear with good and bad region
        // numbers, and intervals that make the running total wrap.
        send_beat(make_beat(rtp_pkg::CMD_READ,  0, 64'd0), 0);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, 0, 64'd100), 0);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, 0, 64'd200), 1);
        send_beat(make_beat(rtp_pkg::CMD_END,   0, 64'd350), 0);
        send_beat(make_beat(rtp_pkg::CMD_END,   0, 64'd400), 2);
        send_beat(make_beat(rtp_pkg::CMD_READ,  0, 64'd0), 0);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, NUM_REGIONS - 1, '1), 0);
        send_beat(make_beat(rtp_pkg::CMD_END,   NUM_REGIONS - 1, 64'd5), 3);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, NUM_REGIONS, 64'd7), 0);
        send_beat(make_beat(rtp_pkg::CMD_END,   255, 64'd9), 0);
        send_beat(make_beat(rtp_pkg::CMD_READ,  128, '1), 1);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, 3, 64'd0), 0);
        send_beat(make_beat(rtp_pkg::CMD_CLEAR, 255, 64'd0), 0);
        send_beat(make_beat(rtp_pkg::CMD_READ,  3, 64'd0), 0);
        send_beat(make_beat(rtp_pkg::CMD_READ,  NUM_REGIONS - 1, 64'd0), 4);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, 7, 64'd10), 0);
        send_beat(make_beat(rtp_pkg::CMD_CLEAR, 7, '1), 0);
        send_beat(make_beat(rtp_pkg::CMD_END,   7, 64'd20), 0);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, 1, 64'd0), 0);
        send_beat(make_beat(rtp_pkg::CMD_END,   1, '1), 0);
        send_beat(make_beat(rtp_pkg::CMD_BEGIN, 1, 64'h8000_0000_0000_0000), 0);
        send_beat(make_beat(rtp_pkg::CMD_END,   1, 64'h7FFF_FFFF_FFFF_FFFF), 0);
        send_beat(make_beat(rtp_pkg::CMD_READ,  1, 64'h5555_AAAA_5555_AAAA), 6);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 150 == 0)
                full_rate = ($urandom_range(3) == 0);
            gap = full_rate ? 0 : $urandom_range(6);
            send_beat(random_beat(), gap);
        end
        item_valid <= 1'b0;

        while (table_model.region_snapshots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_model.errors == 0 && table_model.region_snapshots.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
